// ----- sv/pra_pkg.sv -----
// Package for the pulse rate anemometer: widths, register map, window job
// record and the back-end state type. Used by every module of the block.
`default_nettype none
package pra_pkg;

  // field widths
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned BLADES_W  = 8;
  localparam int unsigned CIRC_W    = 16;
  localparam int unsigned WINDOW_W  = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned SINCE_W   = 3;
  localparam int unsigned RPM_W     = 36;
  localparam int unsigned SPEED_W   = 42;
  localparam int unsigned PROD1_W   = 26;  // count * 1000
  localparam int unsigned DIVISOR_W = ELAPSED_W + BLADES_W;
  localparam int unsigned STEP_W    = 6;

  // configuration register map (word index = paddr[3:2])
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_BLADES    = 2'd1;
  localparam logic [1:0] REG_CIRC      = 2'd2;
  localparam logic [1:0] REG_WINDOW    = 2'd3;

  // reset values of the configuration registers
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd512;
  localparam logic [BLADES_W-1:0] BLADES_RST    = 8'd3;
  localparam logic [CIRC_W-1:0]   CIRC_RST      = 16'd3277;
  localparam logic [WINDOW_W-1:0] WINDOW_RST    = 16'd1000;

  // arithmetic constants
  localparam logic [SINCE_W-1:0]   REFRACTORY_SAMPLES = 3'd5;
  localparam logic [19:0]          RPM_SCALE          = 20'd960000;
  localparam logic [9:0]           MS_PER_SECOND      = 10'd1000;
  localparam logic [COUNT_W-1:0]   COUNT_MAX          = 16'hFFFF;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX        = 17'h1FFFF;
  localparam logic [STEP_W-1:0]    LAST_STEP          = 6'(SPEED_W - 1);

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  // one finished window, handed from front to back
  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    logic [ELAPSED_W-1:0] elapsed;
    logic [BLADES_W-1:0]  blades;
    logic [CIRC_W-1:0]    circ;
  } pra_job_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } pra_state_t;

endpackage
`default_nettype wire

// ----- sv/pra_queue.sv -----
// Short job queue between the front (pulse counting) and the back (division).
// Depends on pra_pkg for the job record and the queue depth.
`default_nettype none
module pra_queue
  import pra_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire pra_job_t push_job,
  output logic          full,
  input  wire logic     pop,
  output logic          nonempty,
  output pra_job_t      head
);

  pra_job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr;
  logic [QUEUE_AW-1:0]     rd_ptr;
  logic [QUEUE_AW:0]       fill;

  assign full     = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign nonempty = (fill != '0);
  assign head     = entries[rd_ptr];

  // store pushed jobs
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && nonempty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && nonempty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/pra_front.sv -----
// Front end: accepts samples and ticks, detects falling threshold crossings,
// counts pulses and times the window. Pushes a job at each window end.
// Depends on pra_pkg.
`default_nettype none
module pra_front
  import pra_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire logic                item_kind,
  input  wire logic [SAMPLE_W-1:0] item_sample,
  input  wire logic [SAMPLE_W-1:0] threshold,
  input  wire logic [BLADES_W-1:0] blade_count,
  input  wire logic [CIRC_W-1:0]   circumference_q16,
  input  wire logic [WINDOW_W-1:0] window_length_ms,
  input  wire logic                queue_full,
  output logic                     push,
  output pra_job_t                 push_job
);

  logic [SAMPLE_W-1:0]  previous_sample;
  logic [SINCE_W-1:0]   samples_since_pulse;
  logic [COUNT_W-1:0]   pulse_total;
  logic [ELAPSED_W-1:0] elapsed_ms;

  logic                 accept;
  logic                 falling;
  logic [SINCE_W-1:0]   since_inc;
  logic                 pulse;
  logic [COUNT_W-1:0]   total_inc;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 window_end;

  // hold off input while the queue cannot take a job
  assign item_ready = !queue_full;
  assign accept     = item_valid && item_ready;

  // classify the item
  always_comb begin
    falling     = (previous_sample >= threshold) && (item_sample < threshold);
    since_inc   = (samples_since_pulse < REFRACTORY_SAMPLES) ?
                  samples_since_pulse + 1'b1 : samples_since_pulse;
    pulse       = falling && (since_inc >= REFRACTORY_SAMPLES);
    total_inc   = (pulse_total < COUNT_MAX) ? pulse_total + 1'b1 : pulse_total;
    elapsed_inc = (elapsed_ms < ELAPSED_MAX) ? elapsed_ms + 1'b1 : elapsed_ms;
    window_end  = (elapsed_inc >= {1'b0, window_length_ms});
  end

  // hand a finished window to the back end
  assign push             = accept && item_kind && window_end;
  assign push_job.count   = pulse_total;
  assign push_job.elapsed = elapsed_inc;
  assign push_job.blades  = blade_count;
  assign push_job.circ    = circumference_q16;

  // update counting state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample     <= '0;
      samples_since_pulse <= '0;
      pulse_total         <= '0;
      elapsed_ms          <= '0;
    end else if (accept) begin
      if (!item_kind) begin
        previous_sample <= item_sample;
        if (pulse) begin
          pulse_total         <= total_inc;
          samples_since_pulse <= '0;
        end else begin
          samples_since_pulse <= since_inc;
        end
      end else if (window_end) begin
        pulse_total <= '0;
        elapsed_ms  <= '0;
      end else begin
        elapsed_ms <= elapsed_inc;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/pra_back.sv -----
// Back end: takes window jobs from the queue, forms both numerators and the
// divisor, runs a shared-step restoring division and drives the result register.
// Depends on pra_pkg.
`default_nettype none
module pra_back
  import pra_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  wire pra_job_t       job,
  output logic                job_pop,
  output logic                res_valid,
  input  wire logic           res_ready,
  output logic [RPM_W-1:0]    res_rpm,
  output logic [SPEED_W-1:0]  res_speed,
  output logic [COUNT_W-1:0]  res_count,
  output logic                res_error
);

  pra_state_t state, state_next;

  // job registers
  logic [COUNT_W-1:0]   count;
  logic [CIRC_W-1:0]    circ;
  logic                 err;
  logic [PROD1_W-1:0]   prod1;
  logic [DIVISOR_W-1:0] divisor;
  logic [SPEED_W-1:0]   rpm_num;
  logic [SPEED_W-1:0]   spd_num;
  logic [DIVISOR_W-1:0] rpm_rem;
  logic [DIVISOR_W-1:0] spd_rem;
  logic [STEP_W-1:0]    step;

  // sequencer controls
  logic load_job;
  logic load_mul;
  logic do_step;
  logic load_out;
  logic out_free;

  // arithmetic
  logic [RPM_W-1:0]     rpm_prod;
  logic [PROD1_W-1:0]   prod1_calc;
  logic [DIVISOR_W-1:0] div_calc;
  logic [SPEED_W-1:0]   spd_prod;
  logic [DIVISOR_W:0]   rpm_sh;
  logic [DIVISOR_W:0]   spd_sh;
  logic                 rpm_ge;
  logic                 spd_ge;
  logic [DIVISOR_W:0]   rpm_diff;
  logic [DIVISOR_W:0]   spd_diff;

  assign out_free = !res_valid || res_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (job_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (step == LAST_STEP) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state decode
  always_comb begin
    load_job = 1'b0;
    load_mul = 1'b0;
    do_step  = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: load_job = job_valid;
      ST_MUL:  load_mul = 1'b1;
      ST_DIV:  do_step  = 1'b1;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  assign job_pop = load_job;

  // first products straight from the queue head
  assign rpm_prod   = {{(RPM_W-COUNT_W){1'b0}}, job.count} *
                      {{(RPM_W-20){1'b0}}, RPM_SCALE};
  assign prod1_calc = {{(PROD1_W-COUNT_W){1'b0}}, job.count} *
                      {{(PROD1_W-10){1'b0}}, MS_PER_SECOND};
  assign div_calc   = {{BLADES_W{1'b0}}, job.elapsed} *
                      {{ELAPSED_W{1'b0}}, job.blades};
  // second product for the speed numerator
  assign spd_prod   = {{(SPEED_W-PROD1_W){1'b0}}, prod1} *
                      {{(SPEED_W-CIRC_W){1'b0}}, circ};

  // one restoring division step on both quotients
  always_comb begin
    rpm_sh   = {rpm_rem, rpm_num[SPEED_W-1]};
    spd_sh   = {spd_rem, spd_num[SPEED_W-1]};
    rpm_ge   = (rpm_sh >= {1'b0, divisor});
    spd_ge   = (spd_sh >= {1'b0, divisor});
    rpm_diff = rpm_sh - {1'b0, divisor};
    spd_diff = spd_sh - {1'b0, divisor};
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (load_job) begin
      count   <= job.count;
      circ    <= job.circ;
      err     <= (job.blades == '0);
      prod1   <= prod1_calc;
      divisor <= div_calc;
      rpm_num <= {{(SPEED_W-RPM_W){1'b0}}, rpm_prod};
    end
    if (load_mul) begin
      spd_num <= spd_prod;
      rpm_rem <= '0;
      spd_rem <= '0;
      step    <= '0;
    end
    if (do_step) begin
      rpm_rem <= rpm_ge ? rpm_diff[DIVISOR_W-1:0] : rpm_sh[DIVISOR_W-1:0];
      spd_rem <= spd_ge ? spd_diff[DIVISOR_W-1:0] : spd_sh[DIVISOR_W-1:0];
      rpm_num <= {rpm_num[SPEED_W-2:0], rpm_ge};
      spd_num <= {spd_num[SPEED_W-2:0], spd_ge};
      step    <= step + 1'b1;
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_rpm   <= err ? '0 : rpm_num[RPM_W-1:0];
      res_speed <= err ? '0 : spd_num;
      res_count <= count;
      res_error <= err;
    end
  end

endmodule
`default_nettype wire

// ----- sv/pulse_rate_anemometer.sv -----
// Pulse rate anemometer top level: APB register file, front end, job queue
// and back end. Depends on pra_pkg, pra_front, pra_queue and pra_back.
//
// Usage:
//   Input stream s_*: s_tuser is the item kind (0 sample, 1 one-millisecond
//   tick), s_tdata[9:0] the photodiode sample. Each accepted item updates
//   the front-end counters and timer; samples and ticks that do not close a
//   window never produce a result.
//   A tick that closes the window queues a job. The back end takes it through
//   the two multiply stages, 42 steps of the restoring divider (set by the
//   42-bit speed numerator) and a load of the result register, which waits
//   until the output register is free.
//   Output stream m_*: m_tdata holds rpm_q4, speed_q16 and pulses_in_window,
//   m_tuser the divide error flag. The result holds while m_tready is low;
//   the queue keeps two more windows, after which s_tready drops.
//   APB port: four registers at byte addresses 0, 4, 8, 12; pready is
//   always high; write only while the block is idle.
//   Reset (rst, synchronous): registers return to their defaults, counters
//   and timer clear, queue and output empty.
`default_nettype none
module pulse_rate_anemometer
  import pra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [9:0] sample_value, [15:10] zero
  input  wire logic        s_tuser,   // [0] kind
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // [35:0] rpm_q4, [77:36] speed_q16,
                                      // [93:78] pulses_in_window, [95:94] zero
  output logic             m_tuser,   // [0] divide_error
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [SAMPLE_W-1:0] threshold;
  logic [BLADES_W-1:0] blade_count;
  logic [CIRC_W-1:0]   circumference_q16;
  logic [WINDOW_W-1:0] window_length_ms;

  logic        cfg_write;
  logic [1:0]  reg_index;

  logic        q_push;
  pra_job_t    q_push_job;
  logic        q_full;
  logic        q_pop;
  logic        q_nonempty;
  pra_job_t    q_head;

  logic [RPM_W-1:0]   res_rpm;
  logic [SPEED_W-1:0] res_speed;
  logic [COUNT_W-1:0] res_count;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold         <= THRESHOLD_RST;
      blade_count       <= BLADES_RST;
      circumference_q16 <= CIRC_RST;
      window_length_ms  <= WINDOW_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_THRESHOLD: threshold         <= pwdata[SAMPLE_W-1:0];
        REG_BLADES:    blade_count       <= pwdata[BLADES_W-1:0];
        REG_CIRC:      circumference_q16 <= pwdata[CIRC_W-1:0];
        REG_WINDOW:    window_length_ms  <= pwdata[WINDOW_W-1:0];
        default:       ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_index)
      REG_THRESHOLD: prdata = {{(32-SAMPLE_W){1'b0}}, threshold};
      REG_BLADES:    prdata = {{(32-BLADES_W){1'b0}}, blade_count};
      REG_CIRC:      prdata = {{(32-CIRC_W){1'b0}}, circumference_q16};
      REG_WINDOW:    prdata = {{(32-WINDOW_W){1'b0}}, window_length_ms};
      default:       prdata = '0;
    endcase
  end

  pra_front u_front (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (s_tvalid),
    .item_ready        (s_tready),
    .item_kind         (s_tuser),
    .item_sample       (s_tdata[SAMPLE_W-1:0]),
    .threshold         (threshold),
    .blade_count       (blade_count),
    .circumference_q16 (circumference_q16),
    .window_length_ms  (window_length_ms),
    .queue_full        (q_full),
    .push              (q_push),
    .push_job          (q_push_job)
  );

  pra_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  pra_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_nonempty),
    .job       (q_head),
    .job_pop   (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_rpm   (res_rpm),
    .res_speed (res_speed),
    .res_count (res_count),
    .res_error (m_tuser)
  );

  assign m_tdata = {2'b00, res_count, res_speed, res_rpm};

endmodule
`default_nettype wire

// ----- bench/tb_pulse_rate_anemometer.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pulse_rate_anemometer: drives sample/tick requests and
// APB writes, predicts every window result and compares it. Depends on pra_pkg.
module tb_pulse_rate_anemometer;
  import pra_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 3000000;
  localparam int unsigned SETTLE_CYCLES   = 60;
  localparam int unsigned IDLE_PCT        = 28;
  localparam int unsigned HOLD_OFF_CYCLES = 500;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS     = 100;
  localparam int unsigned HOLD_PHASE      = 4;
  localparam int unsigned PAUSE_PHASE     = 2;
  localparam int unsigned SMOOTH_PHASE    = 5;
  localparam int unsigned FULL_GROUPS     = 12;
  localparam int unsigned DEBOUNCE        = 5;
  localparam int unsigned REPORT_MAX      = 50;
  localparam logic [63:0] RPM_FACTOR      = 64'd960000;
  localparam logic [63:0] MS_FACTOR       = 64'd1000;
  localparam bit          KIND_SAMPLE     = 1'b0;
  localparam bit          KIND_TICK       = 1'b1;

  typedef struct {
    logic [35:0] rpm_q4;
    logic [41:0] speed_q16;
    logic [15:0] pulses;
    logic        divide_error;
  } window_result_t;

  // Tracks the counter state and the windows whose results are still due
  class window_scoreboard;
    logic [9:0]     threshold;
    logic [7:0]     blades;
    logic [15:0]    circ_q16;
    logic [15:0]    window_ms;
    logic [9:0]     last_sample;
    logic [2:0]     since_pulse;
    logic [15:0]    pulse_count;
    logic [16:0]    elapsed;
    window_result_t pending_windows[$];
    int unsigned    mismatches;

    function new();
      threshold   = THRESHOLD_RST;
      blades      = BLADES_RST;
      circ_q16    = CIRC_RST;
      window_ms   = WINDOW_RST;
      last_sample = '0;
      since_pulse = '0;
      pulse_count = '0;
      elapsed     = '0;
      mismatches  = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_THRESHOLD: threshold = value[9:0];
        REG_BLADES:    blades    = value[7:0];
        REG_CIRC:      circ_q16  = value[15:0];
        REG_WINDOW:    window_ms = value[15:0];
        default: ;
      endcase
    endfunction

    // Advance the counters by one accepted request; queue a result on window end
    function void note_request(bit kind, logic [9:0] sample);
      bit             falling;
      logic [63:0]    divisor;
      logic [63:0]    quot;
      window_result_t res;
      if (kind == KIND_SAMPLE) begin
        falling = (last_sample >= threshold) && (sample < threshold);
        last_sample = sample;
        if (since_pulse < DEBOUNCE) since_pulse++;
        if (falling && since_pulse >= DEBOUNCE) begin
          if (pulse_count != 16'hFFFF) pulse_count++;
          since_pulse = '0;
        end
        return;
      end
      if (elapsed != 17'h1FFFF) elapsed++;
      if (elapsed < {1'b0, window_ms}) return;
      res.pulses       = pulse_count;
      res.divide_error = (blades == 0);
      res.rpm_q4       = '0;
      res.speed_q16    = '0;
      if (blades != 0) begin
        divisor = elapsed * blades;
        quot = pulse_count * RPM_FACTOR / divisor;
        res.rpm_q4 = quot[35:0];
        quot = pulse_count * MS_FACTOR * circ_q16 / divisor;
        res.speed_q16 = quot[41:0];
      end
      pending_windows.push_back(res);
      pulse_count = '0;
      elapsed     = '0;
    endfunction

    task report(string what);
      if (mismatches < REPORT_MAX) $display("%0t: mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compare one delivered result against the oldest due window
    task check_result(logic [95:0] data, logic flag);
      window_result_t want;
      if (pending_windows.size() == 0) begin
        report($sformatf("result with no window due, data %h", data));
        return;
      end
      want = pending_windows.pop_front();
      if (data[35:0] !== want.rpm_q4)
        report($sformatf("rpm_q4 %0d, want %0d", data[35:0], want.rpm_q4));
      if (data[77:36] !== want.speed_q16)
        report($sformatf("speed_q16 %0d, want %0d", data[77:36], want.speed_q16));
      if (data[93:78] !== want.pulses)
        report($sformatf("pulses_in_window %0d, want %0d", data[93:78], want.pulses));
      if (flag !== want.divide_error)
        report($sformatf("divide_error %b, want %b", flag, want.divide_error));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [9:0] sample_value, [15:10] zero
  logic        s_tuser = 1'b0; // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;        // [35:0] rpm_q4, [77:36] speed_q16, [93:78] pulses, [95:94] zero
  logic        m_tuser;        // [0] divide_error
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bit          no_idle = 1'b0;
  bit          hold_off_ask = 1'b0;
  int unsigned cycle_count = 0;
  window_scoreboard sb;

  pulse_rate_anemometer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[pulse_rate_anemometer] ERROR");
      $finish;
    end
  end

  // Accept results; stall at random, and once hold off for a long stretch
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (hold_off_ask && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one request, idling first at random, and hold it until accepted
  task automatic send_request(bit kind, logic [9:0] sample);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, sample};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(kind, sample);
  endtask

  // Drop valid, wait for every due result, then let the back end go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  function automatic logic [9:0] above(logic [9:0] thr);
    return 10'($urandom_range(1023, thr));
  endfunction

  function automatic logic [9:0] below(logic [9:0] thr);
    return (thr == 0) ? 10'd0 : 10'($urandom_range(thr - 1, 0));
  endfunction

  // Square-ish pulse trains around the threshold, with ticks and noise mixed in
  task automatic send_mixed(int unsigned count);
    int unsigned sent;
    int unsigned run;
    bit          high;
    sent = 0;
    high = 1'b1;
    while (sent < count) begin
      run = $urandom_range(6, 1);
      repeat (run) begin
        if ($urandom_range(99) < 25)
          send_request(KIND_TICK, 10'($urandom_range(1023)));
        else if ($urandom_range(99) < 15)
          send_request(KIND_SAMPLE, 10'($urandom_range(1023)));
        else
          send_request(KIND_SAMPLE, high ? above(sb.threshold) : below(sb.threshold));
        sent++;
      end
      high = !high;
    end
  endtask

  initial begin
    int unsigned phase;
    logic [31:0] pick;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: crossings inside and outside the debounce span, full-scale samples
    send_request(KIND_SAMPLE, 10'd1023);
    send_request(KIND_SAMPLE, 10'd0);
    repeat (3) send_request(KIND_SAMPLE, 10'd1023);
    send_request(KIND_SAMPLE, 10'd511);
    send_request(KIND_SAMPLE, 10'd512);
    send_request(KIND_SAMPLE, 10'd0);
    // close the default window
    repeat (1000) send_request(KIND_TICK, 10'd0);
    settle();

    // Zero window length: each tick closes a window; top threshold
    write_reg(REG_WINDOW, 32'd0);
    send_request(KIND_TICK, 10'd1023);
    settle();
    write_reg(REG_THRESHOLD, 32'd1023);
    repeat (5) send_request(KIND_SAMPLE, 10'd1023);
    send_request(KIND_SAMPLE, 10'd1022);
    send_request(KIND_TICK, 10'd0);
    settle();

    // Zero blade count flags an error but still reports the count; zero threshold
    write_reg(REG_BLADES, 32'd0);
    write_reg(REG_CIRC, 32'd65535);
    repeat (5) send_request(KIND_SAMPLE, 10'd1023);
    send_request(KIND_SAMPLE, 10'd0);
    send_request(KIND_TICK, 10'd0);
    settle();
    write_reg(REG_THRESHOLD, 32'd0);
    send_request(KIND_SAMPLE, 10'd1023);
    send_request(KIND_SAMPLE, 10'd0);
    send_request(KIND_TICK, 10'd0);

    // Random settings per phase
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case ($urandom_range(5))
        0: pick = 32'd0;
        1: pick = 32'd1023;
        default: pick = $urandom_range(1023);
      endcase
      write_reg(REG_THRESHOLD, pick);
      case ($urandom_range(5))
        0: pick = 32'd0;
        1: pick = 32'd1;
        2: pick = 32'd255;
        default: pick = $urandom_range(255);
      endcase
      write_reg(REG_BLADES, pick);
      case ($urandom_range(4))
        0: pick = 32'd0;
        1: pick = 32'd65535;
        default: pick = $urandom_range(65535);
      endcase
      write_reg(REG_CIRC, pick);
      case ($urandom_range(4))
        0: pick = 32'd0;
        1: pick = 32'd1;
        2: pick = 32'd2;
        3: pick = $urandom_range(12, 3);
        default: pick = $urandom_range(40, 13);
      endcase
      if (phase == HOLD_PHASE) pick = 32'd0;
      write_reg(REG_WINDOW, pick);

      if (phase == SMOOTH_PHASE) no_idle <= 1'b1;
      // stall the result side while windows keep closing, to back up the input
      if (phase == HOLD_PHASE) begin
        hold_off_ask <= 1'b1;
        repeat (40) send_request(KIND_TICK, 10'($urandom_range(1023)));
      end
      send_mixed(PHASE_ITEMS / 2);
      // pause the input until everything has drained
      if (phase == PAUSE_PHASE) begin
        s_tvalid <= 1'b0;
        while (sb.pending_windows.size() != 0) @(posedge clk);
      end
      send_mixed(PHASE_ITEMS / 2);
      if (phase == SMOOTH_PHASE) no_idle <= 1'b0;
    end

    // One blade and full circumference over one-tick windows, back to back
    settle();
    write_reg(REG_THRESHOLD, 32'd512);
    write_reg(REG_BLADES, 32'd1);
    write_reg(REG_CIRC, 32'd65535);
    write_reg(REG_WINDOW, 32'd1);
    no_idle <= 1'b1;
    send_request(KIND_TICK, 10'($urandom_range(1023)));
    repeat (FULL_GROUPS) begin
      repeat (4) send_request(KIND_SAMPLE, above(10'd512));
      send_request(KIND_SAMPLE, below(10'd512));
    end
    send_request(KIND_TICK, 10'($urandom_range(1023)));
    no_idle <= 1'b0;
    settle();

    if (sb.mismatches == 0 && sb.pending_windows.size() == 0) begin
      $display("[pulse_rate_anemometer] OK");
    end else begin
      $display("[pulse_rate_anemometer] ERROR");
    end
    $finish;
  end

endmodule
